// ===== hdl/ndsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ndsa_pkg: shared types and codes of the name directory slot allocator
// Request and result words, scan packet, cell write command, status codes.
// ----------------------------------------------------------------------------
package ndsa_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int NAME_LIMIT_DEF = 9;

  // Index field of the scan packet and write command, wide enough for 64 slots
  localparam int SCAN_IDX_W = 6;
  localparam int KEY_W      = 64;

  // Operation codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_FULL       = 4'd1;
  localparam logic [3:0] ST_EMPTY_NAME = 4'd2;
  localparam logic [3:0] ST_TOO_LONG   = 4'd3;
  localparam logic [3:0] ST_DUPLICATE  = 4'd4;
  localparam logic [3:0] ST_NO_FREE    = 4'd5;
  localparam logic [3:0] ST_BAD_SLOT   = 4'd6;
  localparam logic [3:0] ST_SLOT_EMPTY = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd8;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] name_key;
    logic [3:0]       name_len;
    logic [4:0]       slot_id;
  } ndsa_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] slot;
    logic [4:0] entry_count;
  } ndsa_out_t;

  // Packet that walks the cell row, collecting first match, first free slot and occupancy of the named slot
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [SCAN_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SCAN_IDX_W-1:0] free_idx;
    logic                  sid_occ;
  } ndsa_scan_t;

  // Broadcast write into one cell
  typedef struct packed {
    logic                  we;
    logic [SCAN_IDX_W-1:0] idx;
    logic                  occ;
    logic [KEY_W-1:0]      name;
  } ndsa_wr_t;

  // Keep the first len characters of a key, clear the rest
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] key,
                                                input logic [3:0] len);
    logic [KEY_W-1:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        res[b*8 +: 8] = key[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/name_directory_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// name_directory_slot_allocator_top: directory of named slots
// Create, delete and search requests over a row of slot cells.
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake            word
//  in_*         in    in_valid/in_ready    ndsa_in_t  (func, key, len, slot id)
//  out_*        out   out_valid/out_ready  ndsa_out_t (status, slot, count)
//
//  A request passes through accept, launch, the scan packet walking the cell
//  row, then a decide/commit step.
//  The cell row length sets the scan length; one request is in flight at a time.
//  Reset (rst_n low, synchronous) clears all slots, the count and the output valid flag.
//  A result waiting on out_ready does not block the next accept; only the
//  commit of that next request waits for the output register to free up.
//
module name_directory_slot_allocator_top #(
  parameter int SLOT_COUNT = ndsa_pkg::SLOT_COUNT_DEF,
  parameter int NAME_LIMIT = ndsa_pkg::NAME_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ndsa_pkg::ndsa_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ndsa_pkg::ndsa_out_t out_data
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOT_COUNT);
  localparam logic [3:0]       LIMIT_C = 4'(NAME_LIMIT);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Request held for the whole scan
  logic [1:0]                 func_r;
  logic [ndsa_pkg::KEY_W-1:0] key_r;
  logic [3:0]                 len_r;
  logic [4:0]                 sid_r;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  ndsa_pkg::ndsa_scan_t tail_r;
  ndsa_pkg::ndsa_out_t  out_r, res;
  logic                 out_valid_r;

  ndsa_pkg::ndsa_scan_t pkt [0:SLOT_COUNT];
  ndsa_pkg::ndsa_wr_t   wr;
  logic [SLOT_COUNT-1:0] vld_vec;

  logic in_fire, out_free, commit, len_bad;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == S_DONE) && out_free;
  assign len_bad  = (len_r == 4'd0) || (len_r >= LIMIT_C);

  // Launch an empty packet into the head of the row
  always_comb begin
    pkt[0]     = '0;
    pkt[0].vld = (state_r == S_LAUNCH);
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ndsa_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key    (key_r),
      .sid    (sid_r),
      .wr     (wr),
      .pkt_in (pkt[i]),
      .pkt_out(pkt[i+1])
    );
    assign vld_vec[i] = pkt[i+1].vld;
  end

  // Sequencer: hold in scan until the packet leaves the last cell
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SCAN;
      S_SCAN:   if (pkt[SLOT_COUNT].vld) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Decide the outcome from the collected scan results
  always_comb begin
    res             = '0;
    res.status      = ndsa_pkg::ST_OK;
    wr              = '0;
    cnt_nxt         = cnt_r;
    unique case (func_r)
      ndsa_pkg::FUNC_CREATE: begin
        priority if (cnt_r >= SLOTS_C) begin
          res.status = ndsa_pkg::ST_FULL;
        end else if (len_r == 4'd0) begin
          res.status = ndsa_pkg::ST_EMPTY_NAME;
        end else if (len_r >= LIMIT_C) begin
          res.status = ndsa_pkg::ST_TOO_LONG;
        end else if (tail_r.hit) begin
          res.status = ndsa_pkg::ST_DUPLICATE;
        end else if (!tail_r.free) begin
          res.status = ndsa_pkg::ST_NO_FREE;
        end else begin
          res.slot = tail_r.free_idx[3:0];
          wr.we    = commit;
          wr.idx   = tail_r.free_idx;
          wr.occ   = 1'b1;
          wr.name  = key_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      ndsa_pkg::FUNC_DELETE: begin
        priority if (32'(sid_r) >= 32'(SLOT_COUNT)) begin
          res.status = ndsa_pkg::ST_BAD_SLOT;
        end else if (!tail_r.sid_occ) begin
          res.status = ndsa_pkg::ST_SLOT_EMPTY;
        end else begin
          wr.we   = commit;
          wr.idx  = ndsa_pkg::SCAN_IDX_W'(sid_r);
          wr.occ  = 1'b0;
          wr.name = '0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      ndsa_pkg::FUNC_SEARCH: begin
        if (len_bad || !tail_r.hit) begin
          res.status = ndsa_pkg::ST_NOT_FOUND;
        end else begin
          res.slot = tail_r.hit_idx[3:0];
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
    res.entry_count = 5'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_data.func;
      key_r  <= ndsa_pkg::norm_key(in_data.name_key, in_data.name_len);
      len_r  <= in_data.name_len;
      sid_r  <= in_data.slot_id;
    end
    if ((state_r == S_SCAN) && pkt[SLOT_COUNT].vld) begin
      tail_r <= pkt[SLOT_COUNT];
    end
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOTS_C)
    else $error("entry count above slot count");

  a_one_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= 1)
    else $error("more than one scan packet in the cell row");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (vld_vec == '0))
    else $error("request accepted while a scan is in flight");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ndsa_pkg::ST_OK)) |-> (out_data.slot == 4'd0))
    else $error("nonzero slot on failed request");
`endif

endmodule

// ===== hdl/ndsa_cell.sv =====
// ----------------------------------------------------------------------------
// ndsa_cell: one directory slot
// Holds occupied mark and name, updates the passing scan packet.
// ----------------------------------------------------------------------------
module ndsa_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ndsa_pkg::KEY_W-1:0] key,
  input  logic [4:0]               sid,
  input  ndsa_pkg::ndsa_wr_t       wr,
  input  ndsa_pkg::ndsa_scan_t     pkt_in,
  output ndsa_pkg::ndsa_scan_t     pkt_out
);

  localparam logic [ndsa_pkg::SCAN_IDX_W-1:0] MY_IDX = ndsa_pkg::SCAN_IDX_W'(IDX);

  logic                       occ_r;
  logic [ndsa_pkg::KEY_W-1:0] name_r;
  ndsa_pkg::ndsa_scan_t       pkt_r;
  ndsa_pkg::ndsa_scan_t       pkt_nxt;
  logic                       sel_wr;

  assign sel_wr = wr.we && (wr.idx == MY_IDX);

  always_comb begin
    pkt_nxt = pkt_in;
    if (pkt_in.vld) begin
      if (!pkt_in.hit && occ_r && (name_r == key)) begin
        pkt_nxt.hit     = 1'b1;
        pkt_nxt.hit_idx = MY_IDX;
      end
      if (!pkt_in.free && !occ_r) begin
        pkt_nxt.free     = 1'b1;
        pkt_nxt.free_idx = MY_IDX;
      end
      if (ndsa_pkg::SCAN_IDX_W'(sid) == MY_IDX) begin
        pkt_nxt.sid_occ = occ_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      name_r <= '0;
      pkt_r  <= '0;
    end else begin
      pkt_r <= pkt_nxt;
      if (sel_wr) begin
        occ_r  <= wr.occ;
        name_r <= wr.name;
      end
    end
  end

  assign pkt_out = pkt_r;

endmodule
